>>> rtl/hgba_pkg.sv
// Shared constants and types for the hash group-by aggregation block.
package hgba_pkg;

    localparam logic [31:0] HASH_MULT = 32'd1300000077;

    localparam int KEY_W  = 32;
    localparam int SUM_W  = 32;
    localparam int SLOT_W = 12;
    localparam int GRP_W  = 13;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [SUM_W-1:0]  group_sum;
        logic [STAT_W-1:0] status;
        logic [GRP_W-1:0]  groups_in_use;
        logic [SUM_W-1:0]  grand_total;
        logic              batch_end_out;
    } res_t;

endpackage

>>> rtl/hgba_item_if.sv
// Input channel: group key, weight and batch mark.
interface hgba_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] group_key;
    logic [31:0]        weight;
    logic               batch_end_in;

    modport source (output valid, output group_key, output weight, output batch_end_in,
                    input ready);
    modport sink (input valid, input group_key, input weight, input batch_end_in,
                  output ready);
endinterface

>>> rtl/hgba_result_if.sv
// Result channel: slot, group sum, status and running totals.
interface hgba_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] slot_index;
    logic [31:0] group_sum;
    logic [1:0]  status;
    logic [12:0] groups_in_use;
    logic [31:0] grand_total;
    logic        batch_end_out;

    modport source (output valid, output slot_index, output group_sum, output status,
                    output groups_in_use, output grand_total, output batch_end_out,
                    input ready);
    modport sink (input valid, input slot_index, input group_sum, input status,
                  input groups_in_use, input grand_total, input batch_end_out,
                  output ready);
endinterface

>>> rtl/hash_group_by_aggregate_top.sv
// Hash group-by aggregation with a linear-probing table in one synchronous memory.
//
// items carries a group key, a weight and a batch mark; results returns one item per
// input: the slot used, the group's new sum, a status code and the running group
// count and grand total. Both channels use valid/ready; an item moves when both are high.
// The key is hashed multiplicatively to a home slot and probed linearly with wrap.
// A key found at its home slot goes through the home, read and check states and, if the
// output register is free, back to idle; each further probe adds one more memory read
// and compare, set by the single read port of the slot memory. A zero key goes from
// idle to the emit state. A full table is probed at every slot before it is reported.
// After reset the slot memory is cleared one entry a cycle, from the first to the last,
// during which items.ready stays low.
// The result sits in an output register; while the receiver stalls the next item is
// still accepted and worked on, and its result waits until the register frees.
module hash_group_by_aggregate_top
    import hgba_pkg::*;
#(
    parameter int TABLE_SIZE = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    hgba_item_if.sink     items,
    hgba_result_if.source results
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int PW    = 32 + IDX_W;
    localparam int ENT_W = KEY_W + SUM_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HOME  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [ENT_W-1:0] slot_mem [TABLE_SIZE];

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic             out_valid_reg, out_valid_next;

    logic [KEY_W-1:0] key_reg;
    logic [SUM_W-1:0] weight_reg;
    logic             mark_reg;
    logic [31:0]      mixed_reg;
    logic [ENT_W-1:0] rd_reg;
    res_t             res_reg;
    res_t             out_reg;

    logic             accept;
    logic             out_free;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [PW-1:0]    home_prod;
    logic [IDX_W-1:0] home_idx;
    logic [KEY_W-1:0] rd_key;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] sum_upd;
    logic [SUM_W-1:0] total_add;
    logic [CNT_W-1:0] count_inc;
    logic [31:0]      idx_ext;
    logic [31:0]      grp_now_ext;
    logic [31:0]      grp_inc_ext;
    res_t             res_comb;
    logic             res_load;
    logic             out_load;

    assign accept    = items.valid && items.ready;
    assign out_free  = !out_valid_reg || results.ready;
    assign home_prod = PW'(mixed_reg) * PW'(TABLE_SIZE);
    assign home_idx  = home_prod[PW-1:32];
    assign rd_key    = rd_reg[ENT_W-1:SUM_W];
    assign rd_sum    = rd_reg[SUM_W-1:0];
    assign sum_upd   = rd_sum + weight_reg;
    assign total_add = total_reg + weight_reg;
    assign count_inc = count_reg + CNT_W'(1);
    assign idx_ext     = 32'(idx_reg);
    assign grp_now_ext = 32'(count_reg);
    assign grp_inc_ext = 32'(count_inc);

    assign items.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        idx_next     = idx_reg;
        probe_next   = probe_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = '0;
        res_comb     = res_reg;
        res_load     = 1'b0;
        out_load     = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (items.group_key == '0)
                    begin
                        res_comb.slot_index    = '0;
                        res_comb.group_sum     = '0;
                        res_comb.status        = ST_ZERO;
                        res_comb.groups_in_use = grp_now_ext[GRP_W-1:0];
                        res_comb.grand_total   = total_reg;
                        res_comb.batch_end_out = items.batch_end_in;
                        res_load               = 1'b1;
                        state_next             = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_HOME;
                    end
                end
            end
            S_HOME:
            begin
                idx_next   = home_idx;
                probe_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_comb.slot_index    = idx_ext[SLOT_W-1:0];
                res_comb.groups_in_use = grp_now_ext[GRP_W-1:0];
                res_comb.grand_total   = total_add;
                res_comb.batch_end_out = mark_reg;
                if (rd_key == key_reg)
                begin
                    mem_we             = 1'b1;
                    mem_wdata          = {key_reg, sum_upd};
                    total_next         = total_add;
                    res_comb.group_sum = sum_upd;
                    res_comb.status    = ST_HIT;
                end
                else if (rd_key == '0)
                begin
                    mem_we                 = 1'b1;
                    mem_wdata              = {key_reg, weight_reg};
                    total_next             = total_add;
                    count_next             = count_inc;
                    res_comb.group_sum     = weight_reg;
                    res_comb.status        = ST_NEW;
                    res_comb.groups_in_use = grp_inc_ext[GRP_W-1:0];
                end
                else
                begin
                    res_comb.slot_index  = '0;
                    res_comb.group_sum   = '0;
                    res_comb.status      = ST_FULL;
                    res_comb.grand_total = total_reg;
                end

                if ((rd_key != key_reg) && (rd_key != '0) && (probe_reg != LAST_IDX))
                begin
                    idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                    probe_next = probe_reg + IDX_W'(1);
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    res_load   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            idx_reg       <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= items.group_key;
            weight_reg <= items.weight;
            mark_reg   <= items.batch_end_in;
            mixed_reg  <= $unsigned(items.group_key) * HASH_MULT;
        end
        if (res_load)
        begin
            res_reg <= res_comb;
        end
        if (out_load)
        begin
            out_reg <= res_comb;
        end
    end

    // Only the read made in the read state is used. A write happens during clear or as an
    // item finishes in the check state; the next used read follows the idle and home states.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= slot_mem[idx_reg];
    end

    assign results.valid         = out_valid_reg;
    assign results.slot_index    = out_reg.slot_index;
    assign results.group_sum     = out_reg.group_sum;
    assign results.status        = out_reg.status;
    assign results.groups_in_use = out_reg.groups_in_use;
    assign results.grand_total   = out_reg.grand_total;
    assign results.batch_end_out = out_reg.batch_end_out;

endmodule

>>> rtl/hgba_checker.sv
// Port-level assertions for the hash group-by aggregation block, bound to the top level.
module hgba_checker
    import hgba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              items_valid,
    input logic              items_ready,
    input logic              results_valid,
    input logic              results_ready,
    input logic [SLOT_W-1:0] slot_index,
    input logic [SUM_W-1:0]  group_sum,
    input logic [STAT_W-1:0] status,
    input logic [SUM_W-1:0]  grand_total
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
        else $error("result dropped while stalled");

    a_payload_stable: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=>
            $stable(slot_index) && $stable(group_sum) && $stable(status)
            && $stable(grand_total))
        else $error("result payload changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        items_valid && items_ready |=> !items_ready)
        else $error("item accepted while the previous one is still at work");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && (status == ST_FULL || status == ST_ZERO) |->
            slot_index == '0 && group_sum == '0)
        else $error("rejected item carries a slot or sum");

endmodule

bind hash_group_by_aggregate_top hgba_checker u_hgba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .items_valid   (items.valid),
    .items_ready   (items.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .slot_index    (results.slot_index),
    .group_sum     (results.group_sum),
    .status        (results.status),
    .grand_total   (results.grand_total)
);
